/* rtl/swaa_pkg.sv */
// Package for the sensor window average alarm block.
// Holds shared types, status and register codes, and parameter defaults.
// No dependencies.
`timescale 1ns / 1ps

package swaa_pkg;

   localparam int DEF_MAX_SENSORS = 16;
   localparam int DEF_WINDOW      = 5;

   localparam logic signed [15:0] COLD_RESET = 16'sd3840;
   localparam logic signed [15:0] WARM_RESET = 16'sd6400;

   typedef enum logic {
      CSR_COLD = 1'b0,
      CSR_WARM = 1'b1
   } csr_index_type;

   typedef enum logic {
      KIND_MAP  = 1'b0,
      KIND_MEAS = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      STS_NORMAL  = 3'd0,
      STS_COLD    = 3'd1,
      STS_WARM    = 3'd2,
      STS_UNKNOWN = 3'd3,
      STS_STORED  = 3'd4,
      STS_FULL    = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOAD,
      S_CHECK,
      S_SAMPLE,
      S_UPDATE,
      S_DIVIDE,
      S_SIGN,
      S_RESULT
   } state_type;

   typedef struct packed {
      kind_type           kind;
      logic [15:0]        sensor_tag;
      logic [15:0]        room_id;
      logic signed [15:0] temperature;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } front_bus_type;

endpackage

/* rtl/sensor_window_average_alarm.sv */
// Top level of the sensor window average alarm block.
// Instantiates swaa_front and swaa_back; holds the limit registers. Uses swaa_pkg.
`timescale 1ns / 1ps

// Usage:
// Request beats on req_* carry either a map entry (kind 0: sensor id and room)
// or a measurement (kind 1: sensor id and Q8.8 temperature). Every request
// beat yields exactly one response beat on rsp_*, in order, with a status,
// the window mean and the room of the matched sensor.
// A two-entry queue takes request beats while the back end works, so
// req_stall rises only when that queue is full.
// A map beat reaches the response register after the load step, a measurement
// against an empty table goes there directly, and one whose sensor is unknown
// gets there after a search of all entries. A known sensor passes through the
// pop, the search, the sample read, the window update, the bit-serial divider
// and the sign and response steps. The back end handles one item at a time.
// The response sits in an output register; while rsp_stall is high it
// holds, and the back end waits with its next result ready.
// Reset (synchronous, active high) empties the queue and the table and restores the
// limits to 3840 and 6400. The user must write the limit registers through csr_*,
// which is always ready, only while the block is idle; the block does not enforce it.

module sensor_window_average_alarm #(
   parameter int MAX_SENSORS = swaa_pkg::DEF_MAX_SENSORS,
   parameter int WINDOW      = swaa_pkg::DEF_WINDOW
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_kind,
   input  logic [15:0]        req_sensor_tag,
   input  logic [15:0]        req_room_id,
   input  logic signed [15:0] req_temperature,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic signed [15:0] rsp_mean_value,
   output logic [15:0]        rsp_room_of_sensor,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [15:0]        csr_wdata
);

   swaa_pkg::front_bus_type front_bus;
   logic                    pop;
   logic signed [15:0]      cold_limit_ff, cold_limit_in;
   logic signed [15:0]      warm_limit_ff, warm_limit_in;

   // The limit registers accept a write in every cycle.
   assign csr_ready = 1'b1;

   always_comb begin
      cold_limit_in = cold_limit_ff;
      warm_limit_in = warm_limit_ff;
      if (csr_valid && csr_ready) begin
         case (swaa_pkg::csr_index_type'(csr_index))
            swaa_pkg::CSR_COLD: cold_limit_in = $signed(csr_wdata);
            swaa_pkg::CSR_WARM: warm_limit_in = $signed(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cold_limit_ff <= swaa_pkg::COLD_RESET;
         warm_limit_ff <= swaa_pkg::WARM_RESET;
      end else begin
         cold_limit_ff <= cold_limit_in;
         warm_limit_ff <= warm_limit_in;
      end
   end

   swaa_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_sensor_tag  (req_sensor_tag),
      .req_room_id     (req_room_id),
      .req_temperature (req_temperature),
      .front_bus       (front_bus),
      .pop             (pop)
   );

   swaa_back #(
      .MAX_SENSORS (MAX_SENSORS),
      .WINDOW      (WINDOW)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .front_bus          (front_bus),
      .pop                (pop),
      .cold_limit         (cold_limit_ff),
      .warm_limit         (warm_limit_ff),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_mean_value     (rsp_mean_value),
      .rsp_room_of_sensor (rsp_room_of_sensor)
   );

`ifndef SYNTHESIS
   // Table loads and rejections carry neither a mean nor a room.
   a_map_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == swaa_pkg::STS_STORED || rsp_status == swaa_pkg::STS_FULL)
      |-> rsp_mean_value == 16'sd0 && rsp_room_of_sensor == 16'd0)
      else $error("map response carries a nonzero mean or room");

   // An unknown sensor changes nothing and reports zeros.
   a_unknown_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == swaa_pkg::STS_UNKNOWN
      |-> rsp_mean_value == 16'sd0 && rsp_room_of_sensor == 16'd0)
      else $error("unknown sensor response carries a nonzero mean or room");

   // A too cold status agrees with the mean and the cold limit in force.
   a_cold_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == swaa_pkg::STS_COLD |-> rsp_mean_value < cold_limit_ff)
      else $error("too cold reported for a mean not below the cold limit");
`endif

endmodule

/* rtl/swaa_front.sv */
// Front part: accepts request beats and queues them with their kind.
// Depends on swaa_pkg.
`timescale 1ns / 1ps

module swaa_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_kind,
   input  logic [15:0]            req_sensor_tag,
   input  logic [15:0]            req_room_id,
   input  logic signed [15:0]     req_temperature,
   output swaa_pkg::front_bus_type front_bus,
   input  logic                   pop
);

   swaa_pkg::item_type q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   logic       do_pop;

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign do_pop    = pop && (cnt_ff != 2'd0);

   assign front_bus.valid = (cnt_ff != 2'd0);
   assign front_bus.item  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push   ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !do_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (do_pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff].kind        <= swaa_pkg::kind_type'(req_kind);
         q_ff[wr_ptr_ff].sensor_tag  <= req_sensor_tag;
         q_ff[wr_ptr_ff].room_id     <= req_room_id;
         q_ff[wr_ptr_ff].temperature <= req_temperature;
      end
   end

endmodule

/* rtl/swaa_back.sv */
// Back part: table search, window update, serial divide and alarm compare.
// Holds the sensor table and sample memories and the response register.
// Depends on swaa_pkg.
`timescale 1ns / 1ps

module swaa_back #(
   parameter int MAX_SENSORS = swaa_pkg::DEF_MAX_SENSORS,
   parameter int WINDOW      = swaa_pkg::DEF_WINDOW
) (
   input  logic                   clock,
   input  logic                   reset,
   input  swaa_pkg::front_bus_type front_bus,
   output logic                   pop,
   input  logic signed [15:0]     cold_limit,
   input  logic signed [15:0]     warm_limit,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [2:0]             rsp_status,
   output logic signed [15:0]     rsp_mean_value,
   output logic [15:0]            rsp_room_of_sensor
);

   localparam int IW    = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
   localparam int CW    = $clog2(MAX_SENSORS + 1);
   localparam int FW    = $clog2(WINDOW + 1);
   localparam int SLW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SUMW  = 16 + $clog2(WINDOW);
   localparam int DEPTH = MAX_SENSORS * WINDOW;
   localparam int SAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DCW   = $clog2(SUMW);

   // Table and sample memories.
   logic [15:0]            sid_mem  [MAX_SENSORS];
   logic [15:0]            room_mem [MAX_SENSORS];
   logic [FW-1:0]          fill_mem [MAX_SENSORS];
   logic [SLW-1:0]         slot_mem [MAX_SENSORS];
   logic signed [SUMW-1:0] sum_mem  [MAX_SENSORS];
   logic signed [15:0]     samp_mem [DEPTH];

   logic [15:0]            rd_sid_ff, rd_room_ff;
   logic [FW-1:0]          rd_fill_ff;
   logic [SLW-1:0]         rd_slot_ff;
   logic signed [SUMW-1:0] rd_sum_ff;
   logic signed [15:0]     samp_rd_ff;

   swaa_pkg::state_type    state_ff, state_in;
   swaa_pkg::item_type     item_ff, item_in;
   logic [CW-1:0]          entry_cnt_ff, entry_cnt_in;
   logic [IW-1:0]          srch_ff, srch_in;
   logic [SAW-1:0]         samp_addr_ff, samp_addr_in;
   logic [FW-1:0]          fill_ff, fill_in;
   logic [SLW-1:0]         slot_ff, slot_in;
   logic signed [SUMW-1:0] sum_ff, sum_in;
   logic [15:0]            room_ff, room_in;
   logic                   neg_ff, neg_in;
   logic [SUMW-1:0]        quo_ff, quo_in;
   logic [FW-1:0]          rem_ff, rem_in;
   logic [FW-1:0]          div_ff, div_in;
   logic [DCW-1:0]         dcnt_ff, dcnt_in;
   swaa_pkg::status_type   res_status_ff, res_status_in;
   logic signed [15:0]     res_mean_ff, res_mean_in;
   logic [15:0]            res_room_ff, res_room_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [2:0]             rsp_status_ff, rsp_status_in;
   logic signed [15:0]     rsp_mean_ff, rsp_mean_in;
   logic [15:0]            rsp_room_ff, rsp_room_in;

   logic                   map_we, hist_we, samp_we;
   logic                   table_full, hit, last_entry, out_free;
   logic [IW-1:0]          wr_addr;
   logic [FW-1:0]          wr_fill, upd_fill;
   logic [SLW-1:0]         wr_slot, upd_slot;
   logic signed [SUMW-1:0] wr_sum, upd_sum;
   logic signed [SUMW:0]   upd_acc;
   logic [FW:0]            rem_sh;
   logic                   rem_ge;
   logic [15:0]            mean_mag;
   logic signed [15:0]     mean_val;

   assign table_full = (entry_cnt_ff == CW'(MAX_SENSORS));
   assign hit        = (rd_sid_ff == item_ff.sensor_tag);
   assign last_entry = ((CW'(srch_ff) + CW'(1)) == entry_cnt_ff);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_mean_value     = rsp_mean_ff;
   assign rsp_room_of_sensor = rsp_room_ff;

   // Window update arithmetic.
   always_comb begin
      if (fill_ff < FW'(WINDOW)) begin
         upd_acc  = (SUMW + 1)'(sum_ff) + (SUMW + 1)'(item_ff.temperature);
         upd_fill = fill_ff + FW'(1);
      end else begin
         upd_acc  = (SUMW + 1)'(sum_ff) - (SUMW + 1)'(samp_rd_ff)
                    + (SUMW + 1)'(item_ff.temperature);
         upd_fill = fill_ff;
      end
      upd_sum  = upd_acc[SUMW-1:0];
      upd_slot = (slot_ff == SLW'(WINDOW - 1)) ? SLW'(0) : slot_ff + SLW'(1);
   end

   // One restoring divide step per cycle on the magnitude.
   always_comb begin
      rem_sh   = {rem_ff, quo_ff[SUMW-1]};
      rem_ge   = (rem_sh >= {1'b0, div_ff});
      mean_mag = quo_ff[15:0];
      mean_val = neg_ff ? -$signed(mean_mag) : $signed(mean_mag);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         swaa_pkg::S_IDLE: begin
            if (front_bus.valid) begin
               if (front_bus.item.kind == swaa_pkg::KIND_MAP) begin
                  state_in = swaa_pkg::S_LOAD;
               end else if (entry_cnt_ff == CW'(0)) begin
                  state_in = swaa_pkg::S_RESULT;
               end else begin
                  state_in = swaa_pkg::S_CHECK;
               end
            end
         end
         swaa_pkg::S_LOAD:   state_in = swaa_pkg::S_RESULT;
         swaa_pkg::S_CHECK: begin
            if (hit) begin
               state_in = swaa_pkg::S_SAMPLE;
            end else if (last_entry) begin
               state_in = swaa_pkg::S_RESULT;
            end
         end
         swaa_pkg::S_SAMPLE: state_in = swaa_pkg::S_UPDATE;
         swaa_pkg::S_UPDATE: state_in = swaa_pkg::S_DIVIDE;
         swaa_pkg::S_DIVIDE: begin
            if (dcnt_ff == DCW'(SUMW - 1)) begin
               state_in = swaa_pkg::S_SIGN;
            end
         end
         swaa_pkg::S_SIGN:   state_in = swaa_pkg::S_RESULT;
         swaa_pkg::S_RESULT: begin
            if (out_free) begin
               state_in = swaa_pkg::S_IDLE;
            end
         end
         default:            state_in = swaa_pkg::S_IDLE;
      endcase
   end

   // Control outputs of the sequencer.
   always_comb begin
      pop     = (state_ff == swaa_pkg::S_IDLE) && front_bus.valid;
      map_we  = (state_ff == swaa_pkg::S_LOAD) && !table_full;
      samp_we = (state_ff == swaa_pkg::S_UPDATE);
      hist_we = map_we || samp_we;
      wr_addr = map_we ? entry_cnt_ff[IW-1:0] : srch_ff;
      wr_fill = map_we ? FW'(0) : upd_fill;
      wr_slot = map_we ? SLW'(0) : upd_slot;
      wr_sum  = map_we ? SUMW'(0) : upd_sum;
   end

   // Datapath next values.
   always_comb begin
      item_in       = item_ff;
      entry_cnt_in  = entry_cnt_ff;
      srch_in       = srch_ff;
      samp_addr_in  = samp_addr_ff;
      fill_in       = fill_ff;
      slot_in       = slot_ff;
      sum_in        = sum_ff;
      room_in       = room_ff;
      neg_in        = neg_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      div_in        = div_ff;
      dcnt_in       = dcnt_ff;
      res_status_in = res_status_ff;
      res_mean_in   = res_mean_ff;
      res_room_in   = res_room_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_mean_in   = rsp_mean_ff;
      rsp_room_in   = rsp_room_ff;
      case (state_ff)
         swaa_pkg::S_IDLE: begin
            if (front_bus.valid) begin
               item_in       = front_bus.item;
               srch_in       = IW'(0);
               res_status_in = swaa_pkg::STS_UNKNOWN;
               res_mean_in   = 16'sd0;
               res_room_in   = 16'd0;
            end
         end
         swaa_pkg::S_LOAD: begin
            if (table_full) begin
               res_status_in = swaa_pkg::STS_FULL;
            end else begin
               res_status_in = swaa_pkg::STS_STORED;
               entry_cnt_in  = entry_cnt_ff + CW'(1);
            end
         end
         swaa_pkg::S_CHECK: begin
            if (hit) begin
               fill_in      = rd_fill_ff;
               slot_in      = rd_slot_ff;
               sum_in       = rd_sum_ff;
               room_in      = rd_room_ff;
               samp_addr_in = SAW'(srch_ff * WINDOW + rd_slot_ff);
            end else if (!last_entry) begin
               srch_in = srch_ff + IW'(1);
            end
         end
         swaa_pkg::S_UPDATE: begin
            neg_in      = upd_sum[SUMW-1];
            quo_in      = upd_sum[SUMW-1] ? SUMW'(-upd_sum) : SUMW'(upd_sum);
            rem_in      = FW'(0);
            div_in      = upd_fill;
            dcnt_in     = DCW'(0);
            res_room_in = room_ff;
         end
         swaa_pkg::S_DIVIDE: begin
            rem_in  = rem_ge ? FW'(rem_sh - {1'b0, div_ff}) : FW'(rem_sh);
            quo_in  = {quo_ff[SUMW-2:0], rem_ge};
            dcnt_in = dcnt_ff + DCW'(1);
         end
         swaa_pkg::S_SIGN: begin
            res_mean_in = mean_val;
            if (mean_val < cold_limit) begin
               res_status_in = swaa_pkg::STS_COLD;
            end else if (mean_val > warm_limit) begin
               res_status_in = swaa_pkg::STS_WARM;
            end else begin
               res_status_in = swaa_pkg::STS_NORMAL;
            end
         end
         swaa_pkg::S_RESULT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_mean_in   = res_mean_ff;
               rsp_room_in   = res_room_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= swaa_pkg::S_IDLE;
         entry_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         entry_cnt_ff <= entry_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      srch_ff       <= srch_in;
      samp_addr_ff  <= samp_addr_in;
      fill_ff       <= fill_in;
      slot_ff       <= slot_in;
      sum_ff        <= sum_in;
      room_ff       <= room_in;
      neg_ff        <= neg_in;
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      div_ff        <= div_in;
      dcnt_ff       <= dcnt_in;
      res_status_ff <= res_status_in;
      res_mean_ff   <= res_mean_in;
      res_room_ff   <= res_room_in;
      rsp_status_ff <= rsp_status_in;
      rsp_mean_ff   <= rsp_mean_in;
      rsp_room_ff   <= rsp_room_in;
   end

   // Table memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (map_we) begin
         sid_mem[wr_addr]  <= item_ff.sensor_tag;
         room_mem[wr_addr] <= item_ff.room_id;
      end
      if (hist_we) begin
         fill_mem[wr_addr] <= wr_fill;
         slot_mem[wr_addr] <= wr_slot;
         sum_mem[wr_addr]  <= wr_sum;
      end
      rd_sid_ff  <= sid_mem[srch_in];
      rd_room_ff <= room_mem[srch_in];
      rd_fill_ff <= fill_mem[srch_in];
      rd_slot_ff <= slot_mem[srch_in];
      rd_sum_ff  <= sum_mem[srch_in];
   end

   // Sample memory.
   always_ff @(posedge clock) begin
      if (samp_we) begin
         samp_mem[samp_addr_ff] <= item_ff.temperature;
      end
      samp_rd_ff <= samp_mem[samp_addr_ff];
   end

endmodule
